// ===== rtl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shorthand for clocked concurrent assertions with asynchronous reset gating.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every rising edge outside reset.
`define FWA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define FWA_ASSERT_IMP(lbl, pre, post, msg) \
	`FWA_ASSERT(lbl, (pre) |-> (post), msg)

// An implication whose consequent is checked in the next cycle.
`define FWA_ASSERT_NXT(lbl, pre, post, msg) \
	`FWA_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== rtl/fwa_pkg.sv =====
// ============================================================================
// fwa_pkg
// Shared types, codes and constants of the frame window block.
// ============================================================================
package fwa_pkg;

	// Default values of the top-level parameters.
	localparam int FWA_MAX_FRAME       = 4096;
	localparam int FWA_PHASE_BITS      = 24;
	localparam int FWA_COS_TABLE_DEPTH = 1024;
	localparam int FWA_SAMPLE_BITS     = 16;

	// Configuration port layout.
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 24;
	localparam int FRAME_LEN_BITS  = 13;
	localparam int PHASE_STEP_BITS = 24;
	localparam int COEF_BITS       = 16;

	localparam logic [FRAME_LEN_BITS-1:0]  FRAME_LEN_RESET  = 13'd1024;
	localparam logic [PHASE_STEP_BITS-1:0] PHASE_STEP_RESET = 24'd16384;

	// Depth of the queue between front and back.
	localparam int FWA_QUEUE_DEPTH = 4;

	// Window constants, Q15 and Q30.
	localparam int FWA_HALF_Q15     = 16384;
	localparam int FWA_ONE_Q15      = 32768;
	localparam int FWA_HAM_BASE_Q30 = 17695 * 32768;
	localparam int FWA_HAM_COS_Q15  = 15073;
	localparam int FWA_BLK_BASE_Q30 = 13763 * 32768;
	localparam int FWA_BLK_COS_Q15  = 16384;
	localparam int FWA_BLK_COS2_Q15 = 2621;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_WINDOW_KIND  = 2'd0,
		REG_FRAME_LENGTH = 2'd1,
		REG_PHASE_STEP   = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		WIN_HANN     = 2'd0,
		WIN_HAMMING  = 2'd1,
		WIN_BLACKMAN = 2'd2
	} win_kind_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fwa_q_stat_t;

endpackage

// ===== rtl/fwa_front.sv =====
// ============================================================================
// fwa_front
// Configuration registers, frame position tracking and input acceptance.
// ============================================================================
module fwa_front #(
	parameter int MAX_FRAME   = fwa_pkg::FWA_MAX_FRAME,
	parameter int PHASE_BITS  = fwa_pkg::FWA_PHASE_BITS,
	parameter int SAMPLE_BITS = fwa_pkg::FWA_SAMPLE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fwa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fwa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample_in,
	input  fwa_pkg::fwa_q_stat_t               q_stat,
	output logic                               push,
	output logic [SAMPLE_BITS-1:0]             item_sample,
	output logic [PHASE_BITS-1:0]              item_phase,
	output logic                               item_last,
	output fwa_pkg::win_kind_t                 kind
);
	import fwa_pkg::*;

	localparam int IDXW = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
	localparam int CMPW = (IDXW + 1 > FRAME_LEN_BITS) ? IDXW + 1 : FRAME_LEN_BITS;
	localparam logic [CMPW-1:0] MAX_LEN = CMPW'(MAX_FRAME);

	win_kind_t                  kind_q;
	logic [FRAME_LEN_BITS-1:0]  frame_len_q;
	logic [PHASE_STEP_BITS-1:0] phase_step_q;
	logic [IDXW-1:0]            sample_index_q;
	logic [PHASE_BITS-1:0]      phase_acc_q;
	logic [CMPW-1:0]            len_ext;
	logic [CMPW-1:0]            len_eff;
	logic [PHASE_BITS-1:0]      step_pb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q       <= WIN_HANN;
			frame_len_q  <= FRAME_LEN_RESET;
			phase_step_q <= PHASE_STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_KIND: begin
					// The unused fourth code behaves as Blackman.
					unique case (cfg_data[1:0])
						2'd0:    kind_q <= WIN_HANN;
						2'd1:    kind_q <= WIN_HAMMING;
						default: kind_q <= WIN_BLACKMAN;
					endcase
				end
				REG_FRAME_LENGTH: frame_len_q  <= cfg_data[FRAME_LEN_BITS-1:0];
				REG_PHASE_STEP:   phase_step_q <= cfg_data[PHASE_STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// A zero length acts as one, an oversized length as the maximum.
	always_comb begin
		len_ext = CMPW'(frame_len_q);
		priority if (len_ext == '0) begin
			len_eff = CMPW'(1);
		end else if (len_ext > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = len_ext;
		end
	end

	// Lowering the length mid-frame ends the frame at the current word.
	assign item_last   = CMPW'(sample_index_q) >= (len_eff - CMPW'(1));
	assign item_sample = sample_in;
	assign item_phase  = phase_acc_q;
	assign in_ready    = !q_stat.full;
	assign push        = in_valid && in_ready;
	assign kind        = kind_q;
	assign step_pb     = PHASE_BITS'(phase_step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			phase_acc_q    <= '0;
		end else if (push) begin
			if (item_last) begin
				sample_index_q <= '0;
				phase_acc_q    <= '0;
			end else begin
				sample_index_q <= sample_index_q + IDXW'(1);
				phase_acc_q    <= phase_acc_q + step_pb;
			end
		end
	end

endmodule

// ===== rtl/fwa_queue.sv =====
// ============================================================================
// fwa_queue
// Short register queue that decouples the front from the back pipeline.
// ============================================================================
module fwa_queue #(
	parameter int WIDTH = 41
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_data,
	input  logic                 pop,
	output logic [WIDTH-1:0]     pop_data,
	output fwa_pkg::fwa_q_stat_t stat
);
	import fwa_pkg::*;

	localparam int PTR_BITS = (FWA_QUEUE_DEPTH > 2) ? $clog2(FWA_QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(FWA_QUEUE_DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(FWA_QUEUE_DEPTH - 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(FWA_QUEUE_DEPTH);

	logic [WIDTH-1:0]    mem_q [FWA_QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

endmodule

// ===== rtl/fwa_back.sv =====
// ============================================================================
// fwa_back
// Cosine lookup, window coefficient and product pipeline with output register.
// ============================================================================
module fwa_back #(
	parameter int PHASE_BITS      = fwa_pkg::FWA_PHASE_BITS,
	parameter int COS_TABLE_DEPTH = fwa_pkg::FWA_COS_TABLE_DEPTH,
	parameter int SAMPLE_BITS     = fwa_pkg::FWA_SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fwa_pkg::win_kind_t              kind,
	input  fwa_pkg::fwa_q_stat_t            q_stat,
	input  logic [SAMPLE_BITS-1:0]          head_sample,
	input  logic [PHASE_BITS-1:0]           head_phase,
	input  logic                            head_last,
	output logic                            pop,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic signed [SAMPLE_BITS-1:0]   windowed_sample,
	output logic [fwa_pkg::COEF_BITS-1:0]   window_coef,
	output logic                            frame_last
);
	import fwa_pkg::*;

	localparam int QB = PHASE_BITS - 2;
	localparam int IW = $clog2(COS_TABLE_DEPTH + 1);
	localparam int PW = SAMPLE_BITS + 17;
	localparam int TAYLOR_TERMS = 12;
	localparam logic [IW-1:0] D_IDX = IW'(COS_TABLE_DEPTH);
	localparam longint unsigned PIH_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
		'{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
		  64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};
	localparam logic signed [PW-1:0] SMAX = {{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [PW-1:0] SMIN = ~SMAX;

	// Quarter-wave cosine at k/D of pi/2, Taylor series in Q30, rounded to Q15.
	function automatic logic [COEF_BITS-1:0] quarter_cos(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x    = (longint'(k) * PIH_Q30) / COS_TABLE_DEPTH;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = 64'sd1 << 30;
		for (int n = 0; n < TAYLOR_TERMS; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if (n[0] == 1'b0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		sum = (sum + 64'sd16384) >>> 15;
		if (sum > 64'sd32768) begin
			sum = 64'sd32768;
		end
		return COEF_BITS'(sum);
	endfunction

	// Folds a phase onto the quarter table: {negate, table address}.
	function automatic logic [IW:0] map_phase(input logic [PHASE_BITS-1:0] p);
		logic [QB+IW-1:0] scaled;
		logic [IW-1:0]    idx;
		logic [1:0]       quad;
		quad   = p[PHASE_BITS-1 -: 2];
		scaled = (QB+IW)'(p[QB-1:0]) * (QB+IW)'(COS_TABLE_DEPTH);
		idx    = scaled[QB+IW-1:QB];
		return {quad[1] ^ quad[0], quad[0] ? (D_IDX - idx) : idx};
	endfunction

	logic [COEF_BITS-1:0]          cos_rom [COS_TABLE_DEPTH+1];

	logic                          adv;
	logic [PHASE_BITS-1:0]         phase_b;
	logic [IW:0]                   map_a;
	logic [IW:0]                   map_b;

	logic                          v_s1, v_s2, v_s3, v_s4;
	logic [COEF_BITS-1:0]          rom_a_s1, rom_b_s1;
	logic                          neg_a_s1, neg_b_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1, sample_s2, sample_s3;
	logic                          last_s1, last_s2, last_s3, last_s4;
	logic signed [16:0]            c_s2;
	logic signed [31:0]            mul_a_s2, mul_b_s2;
	logic [COEF_BITS-1:0]          coef_s3, coef_s4;
	logic signed [PW-1:0]          prod_s4;

	logic signed [16:0]            c_a, c_b;
	logic signed [31:0]            k_a;
	logic signed [17:0]            hann_t;
	logic signed [31:0]            sum_t;
	logic signed [31:0]            rnd_t;
	logic [COEF_BITS-1:0]          coef_d;
	logic signed [PW-1:0]          prod_rnd;
	logic signed [PW-1:0]          prod_sh;
	logic signed [SAMPLE_BITS-1:0] win_d;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] windowed_q;
	logic [COEF_BITS-1:0]          coef_q;
	logic                          last_q;

	// The quarter table is a set of elaboration-time constants.
	for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_cos_rom
		localparam logic [COEF_BITS-1:0] ROM_VAL = quarter_cos(k);
		assign cos_rom[k] = ROM_VAL;
	end

	// The whole pipeline moves together whenever the output register can take a word.
	assign adv     = !out_valid_q || out_ready;
	assign pop     = adv && !q_stat.empty;
	assign phase_b = {head_phase[PHASE_BITS-2:0], 1'b0};
	assign map_a   = map_phase(head_phase);
	assign map_b   = map_phase(phase_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	// Stage 1: two table reads, one for the cosine and one for the double-angle cosine.
	always_ff @(posedge clk) begin
		if (adv) begin
			rom_a_s1  <= cos_rom[map_a[IW-1:0]];
			rom_b_s1  <= cos_rom[map_b[IW-1:0]];
			neg_a_s1  <= map_a[IW];
			neg_b_s1  <= map_b[IW];
			sample_s1 <= $signed(head_sample);
			last_s1   <= head_last;
		end
	end

	// Stage 2: signed cosines and their weighted terms.
	always_comb begin
		c_a = neg_a_s1 ? -$signed({1'b0, rom_a_s1}) : $signed({1'b0, rom_a_s1});
		c_b = neg_b_s1 ? -$signed({1'b0, rom_b_s1}) : $signed({1'b0, rom_b_s1});
		k_a = (kind == WIN_HAMMING) ? 32'(FWA_HAM_COS_Q15) : 32'(FWA_BLK_COS_Q15);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s2      <= c_a;
			mul_a_s2  <= k_a * c_a;
			mul_b_s2  <= 32'(FWA_BLK_COS2_Q15) * c_b;
			sample_s2 <= sample_s1;
			last_s2   <= last_s1;
		end
	end

	// Stage 3: window coefficient, rounded half up; Hamming and Blackman are clamped to [0, one].
	always_comb begin
		hann_t = 18'sd32769 - 18'(c_s2);
		sum_t  = '0;
		rnd_t  = '0;
		coef_d = '0;
		unique case (kind)
			WIN_HANN: begin
				coef_d = COEF_BITS'(hann_t >>> 1);
			end
			WIN_HAMMING: begin
				sum_t = 32'(FWA_HAM_BASE_Q30) - mul_a_s2;
			end
			default: begin
				sum_t = 32'(FWA_BLK_BASE_Q30) - mul_a_s2 + mul_b_s2;
			end
		endcase
		if (kind != WIN_HANN) begin
			rnd_t = (sum_t + 32'(FWA_HALF_Q15)) >>> 15;
			priority if (rnd_t < 0) begin
				coef_d = '0;
			end else if (rnd_t > 32'(FWA_ONE_Q15)) begin
				coef_d = COEF_BITS'(FWA_ONE_Q15);
			end else begin
				coef_d = rnd_t[COEF_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_s3   <= coef_d;
			sample_s3 <= sample_s2;
			last_s3   <= last_s2;
		end
	end

	// Stage 4: sample times coefficient.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= PW'(sample_s3) * PW'($signed({1'b0, coef_s3}));
			coef_s4 <= coef_s3;
			last_s4 <= last_s3;
		end
	end

	// Output stage: round half up to Q1.15 and saturate.
	always_comb begin
		prod_rnd = prod_s4 + PW'(FWA_HALF_Q15);
		prod_sh  = prod_rnd >>> 15;
		priority if (prod_sh > SMAX) begin
			win_d = SMAX[SAMPLE_BITS-1:0];
		end else if (prod_sh < SMIN) begin
			win_d = SMIN[SAMPLE_BITS-1:0];
		end else begin
			win_d = prod_sh[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			windowed_q <= win_d;
			coef_q     <= coef_s4;
			last_q     <= last_s4;
		end
	end

	assign out_valid       = out_valid_q;
	assign windowed_sample = windowed_q;
	assign window_coef     = coef_q;
	assign frame_last      = last_q;

endmodule

// ===== rtl/frame_window_apply_top.sv =====
// ============================================================================
// frame_window_apply_top
// Applies a Hann, Hamming or Blackman window to a stream of frame samples.
// ============================================================================
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------
//  input    | in_valid / in_ready    | sample_in
//  output   | out_valid / out_ready  | windowed_sample, window_coef, frame_last
//  config   | cfg_we                 | cfg_index, cfg_data
//
//  One word per cycle sustained while out_ready is high; the cosine
//  table's two read ports (the cosine and the double-angle cosine) each serve
//  one word per cycle. An input word passes through the queue, stages 1 to 4
//  and the output register before its result shows. Reset clears the frame
//  position and loads the register defaults; the cosine table is a constant
//  and needs no fill after reset. While a result waits on out_ready the back
//  pipeline holds; the four-entry queue keeps in_ready high until it fills.
//
module frame_window_apply_top #(
	parameter int MAX_FRAME       = fwa_pkg::FWA_MAX_FRAME,
	parameter int PHASE_BITS      = fwa_pkg::FWA_PHASE_BITS,
	parameter int COS_TABLE_DEPTH = fwa_pkg::FWA_COS_TABLE_DEPTH,
	parameter int SAMPLE_BITS     = fwa_pkg::FWA_SAMPLE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fwa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fwa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      sample_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [SAMPLE_BITS-1:0]      windowed_sample,
	output logic [fwa_pkg::COEF_BITS-1:0]      window_coef,
	output logic                               frame_last
);
	import fwa_pkg::*;

	localparam int QW = SAMPLE_BITS + PHASE_BITS + 1;

	fwa_q_stat_t             q_stat;
	win_kind_t               kind;
	logic                    push;
	logic                    pop;
	logic [SAMPLE_BITS-1:0]  item_sample;
	logic [PHASE_BITS-1:0]   item_phase;
	logic                    item_last;
	logic [QW-1:0]           head_data;

	fwa_front #(
		.MAX_FRAME   (MAX_FRAME),
		.PHASE_BITS  (PHASE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_in   (sample_in),
		.q_stat      (q_stat),
		.push        (push),
		.item_sample (item_sample),
		.item_phase  (item_phase),
		.item_last   (item_last),
		.kind        (kind)
	);

	fwa_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({item_last, item_phase, item_sample}),
		.pop       (pop),
		.pop_data  (head_data),
		.stat      (q_stat)
	);

	fwa_back #(
		.PHASE_BITS      (PHASE_BITS),
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.kind            (kind),
		.q_stat          (q_stat),
		.head_sample     (head_data[SAMPLE_BITS-1:0]),
		.head_phase      (head_data[SAMPLE_BITS +: PHASE_BITS]),
		.head_last       (head_data[QW-1]),
		.pop             (pop),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.windowed_sample (windowed_sample),
		.window_coef     (window_coef),
		.frame_last      (frame_last)
	);

endmodule

// ===== rtl/fwa_checker.sv =====
// ============================================================================
// fwa_checker
// Port-level checks of the frame window block, bound to its top level.
// ============================================================================
`include "assert_macros.svh"

module fwa_checker #(
	parameter int SAMPLE_BITS = fwa_pkg::FWA_SAMPLE_BITS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] windowed_sample,
	input logic [fwa_pkg::COEF_BITS-1:0] window_coef,
	input logic                          frame_last
);
	import fwa_pkg::*;

	localparam int PEND_BITS = 5;

	logic                 in_acc;
	logic                 out_acc;
	logic [PEND_BITS-1:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Words accepted at the input whose results have not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + PEND_BITS'(1);
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - PEND_BITS'(1);
		end
	end

	`FWA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(windowed_sample) && $stable(window_coef) && $stable(frame_last), "stalled result changed")
	`FWA_ASSERT_IMP(a_no_invented, out_valid, pending_q != '0, "result without an input word")
	`FWA_ASSERT_IMP(a_ready_backlog, !in_ready, pending_q != '0, "input stalled with nothing in flight")
	`FWA_ASSERT_IMP(a_coef_range, out_valid, (window_coef <= 16'd32768) && ((window_coef != '0) || (windowed_sample == '0)), "coefficient out of range or zero coefficient gave nonzero output")

endmodule

bind frame_window_apply_top fwa_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fwa_checker (.*);
